// ===== design/sxed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxed_pkg: shared types and constants of the STX/LEN/XOR/ETX deframer
// Result word layout, kind and status codes, parser phases, register map.
// ----------------------------------------------------------------------------
package sxed_pkg;

	localparam logic [7:0] MIN_BODY_LEN = 8'd3;

	localparam logic [7:0] START_BYTE_RST = 8'hAA;
	localparam logic [7:0] END_BYTE_RST   = 8'h55;

	localparam int         PADDR_W   = 3;
	localparam logic       REG_START = 1'b0;
	localparam logic       REG_END   = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_BODY = 3'd2,
		PH_SUM  = 3'd3,
		PH_END  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		KIND_CMD    = 3'd0,
		KIND_SUBCMD = 3'd1,
		KIND_CHAN   = 3'd2,
		KIND_DATA   = 3'd3,
		KIND_STATUS = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_LEN_ERR = 2'd1,
		ST_SUM_ERR = 2'd2,
		ST_END_ERR = 2'd3
	} stat_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		stat_t      status;
		logic       frame_end;
	} res_t;

endpackage

// ===== design/sxed_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxed_front: frame parser
// Accepts received bytes, tracks the frame phase, keeps the running XOR and
// emits tagged body words and the closing status word.
// ----------------------------------------------------------------------------
module sxed_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        start_byte,
	input  logic [7:0]        end_byte,
	output logic              push,
	output sxed_pkg::res_t    push_res
);
	import sxed_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] body_left_q, body_left_d;
	logic [1:0] body_pos_q, body_pos_d;
	logic [7:0] xor_q, xor_d;
	logic       sum_bad_q, sum_bad_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			body_left_q <= 8'd0;
			body_pos_q  <= 2'd0;
			xor_q       <= 8'd0;
			sum_bad_q   <= 1'b0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			body_left_q <= body_left_d;
			body_pos_q  <= body_pos_d;
			xor_q       <= xor_d;
			sum_bad_q   <= sum_bad_d;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		body_left_d   = body_left_q;
		body_pos_d    = body_pos_q;
		xor_d         = xor_q;
		sum_bad_d     = sum_bad_q;
		push          = 1'b0;
		push_res.kind      = KIND_STATUS;
		push_res.value     = 8'd0;
		push_res.status    = ST_OK;
		push_res.frame_end = 1'b0;
		case (phase_q)
			PH_LEN: begin
				if (rx_byte < MIN_BODY_LEN) begin
					phase_d            = PH_HUNT;
					push               = in_fire;
					push_res.status    = ST_LEN_ERR;
					push_res.frame_end = 1'b1;
				end else begin
					body_left_d = rx_byte;
					body_pos_d  = 2'd0;
					xor_d       = 8'd0;
					sum_bad_d   = 1'b0;
					phase_d     = (rx_byte == 8'd0) ? PH_SUM : PH_BODY;
				end
			end
			PH_BODY: begin
				push           = in_fire;
				push_res.kind  = kind_t'({1'b0, body_pos_q});
				push_res.value = rx_byte;
				xor_d          = xor_q ^ rx_byte;
				if (body_pos_q != 2'd3)
					body_pos_d = body_pos_q + 2'd1;
				body_left_d = body_left_q - 8'd1;
				if (body_left_d == 8'd0)
					phase_d = PH_SUM;
			end
			PH_SUM: begin
				sum_bad_d = (rx_byte != xor_q);
				phase_d   = PH_END;
			end
			PH_END: begin
				phase_d            = PH_HUNT;
				push               = in_fire;
				push_res.frame_end = 1'b1;
				if (rx_byte != end_byte)
					push_res.status = ST_END_ERR;
				else if (sum_bad_q)
					push_res.status = ST_SUM_ERR;
				else
					push_res.status = ST_OK;
			end
			default: begin
				phase_d = (rx_byte == start_byte) ? PH_LEN : PH_HUNT;
			end
		endcase
	end

	a_status_restarts_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_res.kind == KIND_STATUS |=> phase_q == PH_HUNT)
		else $error("status word did not restart the hunt");

	a_body_only_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_res.kind != KIND_STATUS |-> phase_q == PH_BODY && !push_res.frame_end)
		else $error("body word outside body phase");

endmodule

// ===== design/sxed_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxed_queue: result word queue
// Short FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module sxed_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sxed_pkg::res_t    push_res,
	input  logic              pop,
	output sxed_pkg::res_t    head_res,
	output logic              empty,
	output logic              full
);
	import sxed_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty    = (count_q == CW'(0));
	assign full     = (count_q == CW'(DEPTH));
	assign head_res = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

// ===== design/sxed_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxed_back: output stage
// Pulls result words from the queue into the master-side output register.
// ----------------------------------------------------------------------------
module sxed_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  sxed_pkg::res_t    head_res,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);
	import sxed_pkg::*;

	logic tvalid_q;
	res_t out_q;

	assign pop = !q_empty && (!tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tvalid_q <= 1'b0;
		else if (!tvalid_q || m_tready)
			tvalid_q <= !q_empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= head_res;
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = {6'd0, out_q.status, out_q.value};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.frame_end;

	a_load_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> tvalid_q)
		else $error("loaded word not presented");

endmodule

// ===== design/stx_len_xor_etx_deframer.sv =====
`timescale 1ns / 1ps
// Each result word passes through the result queue, then the output register.
// Throughput: one byte per cycle; s_tready drops only while the result queue
// (FIFO_DEPTH words) is full, so it follows the downstream tready.
// Reset: arst_n clears the parser to hunting, empties the queue, drops
// m_tvalid and restores start_byte to 0xAA and end_byte to 0x55.
// ----------------------------------------------------------------------------
// stx_len_xor_etx_deframer: serial frame deframer
// Parser front end, result queue and output stage, with an APB register port
// for the start and end marker bytes.
// ----------------------------------------------------------------------------
module stx_len_xor_etx_deframer #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,   // [7:0] value, [9:8] status
	output logic [2:0]                  m_tuser,   // [2:0] kind
	output logic                        m_tlast,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sxed_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import sxed_pkg::*;

	logic [7:0] start_byte_q, end_byte_q;
	logic       cfg_wr, in_fire, push, pop, q_empty, q_full;
	res_t       push_res, head_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_START)
				start_byte_q <= pwdata[7:0];
			else
				end_byte_q <= pwdata[7:0];
		end
	end

	assign prdata = {24'd0, (paddr[2] == REG_END) ? end_byte_q : start_byte_q};

	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	sxed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.rx_byte    (s_tdata),
		.start_byte (start_byte_q),
		.end_byte   (end_byte_q),
		.push       (push),
		.push_res   (push_res)
	);

	sxed_queue #(
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.pop      (pop),
		.head_res (head_res),
		.empty    (q_empty),
		.full     (q_full)
	);

	sxed_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head_res (head_res),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== dv/sxed_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxed_frame_checker: result checker for the STX/LEN/XOR/ETX deframer
// Watches the byte stream, the result stream and the register port, keeps its
// own copy of the parser state and of the marker bytes, queues the result
// word each accepted byte should cause and compares every accepted result
// word, field by field, with the oldest queued one.
// ----------------------------------------------------------------------------
module sxed_frame_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [15:0]                   m_tdata,   // [7:0] value, [9:8] status
	input  logic [2:0]                    m_tuser,   // [2:0] kind
	input  logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sxed_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          pready,
	output int                            fail_count,
	output int                            pending
);
	import sxed_pkg::*;

	res_t       exp_words[$];
	res_t       want;
	phase_t     phase;
	logic [7:0] body_left;
	logic [1:0] body_pos;
	logic [7:0] run_xor;
	logic       sum_bad;
	logic [7:0] cfg_start;
	logic [7:0] cfg_end;
	int         mismatches = 0;
	int         n_queued = 0;

	assign fail_count = mismatches;
	assign pending    = n_queued;

	task automatic report(input string what, input int got, input int exp_val);
		$display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got,
			exp_val);
		mismatches++;
	endtask

	task automatic parse_byte(input logic [7:0] b);
		res_t w;
		bit   has_word;
		w        = '0;
		has_word = 1'b0;
		case (phase)
			PH_LEN: begin
				if (b < MIN_BODY_LEN) begin
					phase    = PH_HUNT;
					w.kind   = KIND_STATUS;
					w.status = ST_LEN_ERR;
					w.frame_end = 1'b1;
					has_word = 1'b1;
				end else begin
					body_left = b;
					body_pos  = 2'd0;
					run_xor   = 8'd0;
					sum_bad   = 1'b0;
					phase     = (b == 8'd0) ? PH_SUM : PH_BODY;
				end
			end
			PH_BODY: begin
				w.kind   = kind_t'({1'b0, body_pos});
				w.value  = b;
				w.status = ST_OK;
				has_word = 1'b1;
				run_xor  = run_xor ^ b;
				if (body_pos != 2'd3)
					body_pos = body_pos + 2'd1;
				body_left = body_left - 8'd1;
				if (body_left == 8'd0)
					phase = PH_SUM;
			end
			PH_SUM: begin
				sum_bad = (b != run_xor);
				phase   = PH_END;
			end
			PH_END: begin
				if (b != cfg_end)
					w.status = ST_END_ERR;
				else if (sum_bad)
					w.status = ST_SUM_ERR;
				else
					w.status = ST_OK;
				w.kind      = KIND_STATUS;
				w.frame_end = 1'b1;
				has_word    = 1'b1;
				phase       = PH_HUNT;
			end
			default: begin
				phase = (b == cfg_start) ? PH_LEN : PH_HUNT;
			end
		endcase
		if (has_word)
			exp_words.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_words.delete();
			phase     = PH_HUNT;
			body_left = 8'd0;
			body_pos  = 2'd0;
			run_xor   = 8'd0;
			sum_bad   = 1'b0;
			cfg_start = START_BYTE_RST;
			cfg_end   = END_BYTE_RST;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == PADDR_W'({REG_START, 2'b00}))
					cfg_start = pwdata[7:0];
				else if (paddr == PADDR_W'({REG_END, 2'b00}))
					cfg_end = pwdata[7:0];
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (exp_words.size() == 0) begin
					report("word with nothing pending", m_tdata, 0);
				end else begin
					want = exp_words.pop_front();
					if (m_tuser !== want.kind)
						report("kind", m_tuser, want.kind);
					if (m_tdata[7:0] !== want.value)
						report("value", m_tdata[7:0], want.value);
					if (m_tdata[9:8] !== want.status)
						report("status", m_tdata[9:8], want.status);
					if (m_tlast !== want.frame_end)
						report("frame_end", m_tlast, want.frame_end);
				end
			end
		end
		n_queued = exp_words.size();
	end

endmodule

// ===== dv/stx_len_xor_etx_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_len_xor_etx_deframer_tb: regression bench for the serial frame deframer
// Feeds directed frames (reset markers, short lengths, combined checksum and
// end errors), then random well-formed, corrupted, truncated and noise byte
// sequences under several marker settings, with random idling on both
// streams. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module stx_len_xor_etx_deframer_tb;
	import sxed_pkg::*;

	localparam int IDLE_PCT        = 29;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int BYTES_PER_PHASE = 470;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata  = 8'd0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [15:0]        m_tdata;
	logic [2:0]         m_tuser;
	logic               m_tlast;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [PADDR_W-1:0] paddr    = '0;
	logic [31:0]        pwdata   = 32'd0;
	logic [31:0]        prdata;
	logic               pready;

	bit                 steady    = 1'b0;
	logic [7:0]         cur_start = START_BYTE_RST;
	logic [7:0]         cur_end   = END_BYTE_RST;
	logic [7:0]         body_q[$];
	int                 sent      = 0;
	int                 idle_cycles;
	int                 fail_count;
	int                 pending;

	stx_len_xor_etx_deframer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	sxed_frame_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_word(input logic [7:0] b);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_markers(input logic [7:0] stx, input logic [7:0] etx);
		write_reg(REG_START, stx);
		write_reg(REG_END, etx);
		cur_start = stx;
		cur_end   = etx;
	endtask

	task automatic send_frame(input bit bad_sum, input bit bad_end);
		logic [7:0] sum;
		sum = 8'd0;
		send_word(cur_start);
		send_word(8'(body_q.size()));
		foreach (body_q[i]) begin
			send_word(body_q[i]);
			sum = sum ^ body_q[i];
		end
		if (bad_sum)
			sum = sum ^ 8'($urandom_range(255, 1));
		send_word(sum);
		send_word(bad_end ? (cur_end ^ 8'($urandom_range(255, 1))) : cur_end);
	endtask

	task automatic send_short(input logic [7:0] len);
		send_word(cur_start);
		send_word(len);
	endtask

	task automatic random_phase(input int n);
		int         first;
		int         pick;
		int         len;
		logic [7:0] b;
		first = sent;
		while (sent - first < n) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				pick = $urandom_range(99);
				if (pick < 4)
					len = $urandom_range(255, 128);
				else if (pick < 10)
					len = $urandom_range(127, 13);
				else
					len = $urandom_range(12, MIN_BODY_LEN);
				body_q.delete();
				repeat (len) body_q.push_back(8'($urandom));
				send_frame($urandom_range(99) < 12, $urandom_range(99) < 12);
			end else if (pick < 80) begin
				send_short(8'($urandom_range(MIN_BODY_LEN - 1)));
			end else if (pick < 90) begin
				repeat ($urandom_range(6, 1)) begin
					b = 8'($urandom);
					if (b == cur_start && $urandom_range(9) != 0)
						b = ~b;
					send_word(b);
				end
			end else begin
				// truncate: the next bytes are taken as the rest of the body
				len = $urandom_range(10, MIN_BODY_LEN);
				send_short(8'(len));
				repeat ($urandom_range(len - 1, 1)) send_word(8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(8'h00);
		send_word(8'hFF);
		body_q = '{8'h00, 8'hFF, 8'h5A, 8'hC3};
		send_frame(1'b0, 1'b0);
		send_short(8'd0);
		send_short(MIN_BODY_LEN - 8'd1);
		body_q = '{8'h81, 8'h7E, 8'h11};
		send_frame(1'b1, 1'b1);

		drain();
		set_markers(8'h00, 8'hFF);
		random_phase(BYTES_PER_PHASE);

		drain();
		set_markers(8'hFF, 8'h00);
		steady = 1'b1;
		random_phase(BYTES_PER_PHASE);
		steady = 1'b0;

		drain();
		set_markers(8'($urandom), 8'($urandom));
		random_phase(BYTES_PER_PHASE / 2);
		drain();
		random_phase(BYTES_PER_PHASE / 2);

		drain();
		set_markers(START_BYTE_RST, END_BYTE_RST);
		random_phase(BYTES_PER_PHASE);

		drain();
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
